/* rtl/core/rpbf_pkg.sv */
// Package for the record-preserving byte FIFO: payload structs, codes, defaults
// and the command/status bundles between controller and datapath.
// No dependencies.
package rpbf_pkg;

  // Default sizes; the top level takes these as parameter defaults.
  localparam int STORE_BYTES_DEF    = 4096;
  localparam int RECORD_SLOTS_DEF   = 64;
  localparam int READ_MAX_BYTES_DEF = 64;

  // Fixed field widths.
  localparam int CNT_W   = 13;
  localparam int RMAX_W  = 7;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register index, decoded from the word address bit of the config port.
  localparam logic REG_SOCKET_KIND = 1'b0;

  // Socket kind codes.
  localparam logic [1:0] SK_STREAM = 2'd0;
  localparam logic [1:0] SK_DGRAM  = 2'd1;
  localparam logic [1:0] SK_SEQPKT = 2'd2;

  // Input item mode codes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_WSTAT = 2'd0;
  localparam logic [1:0] KIND_RDATA = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [7:0]        data_byte;
    logic              end_of_record;
    logic [RMAX_W-1:0] read_max;
  } rpbf_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [CNT_W-1:0] count;
    logic             last;
  } rpbf_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic wr_acc;     // accept a write byte
    logic emit_none;  // load a "found nothing" result
    logic len_rd;     // accept a read: fetch head length, pop queue in record mode, latch max
    logic ld_len;     // latch byte count and consumption
    logic rp_adv;     // advance read pointer by the consumption
    logic idx_clr;    // restart the byte index
    logic idx_inc;    // step the byte index
    logic byte_rd;    // fetch a byte from the store
    logic emit_byte;  // load a read data result
  } rpbf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic nothing;    // a read now would find nothing
    logic n_zero;     // fetched record gives zero bytes
    logic last_byte;  // current byte is the final one of this read
  } rpbf_stat_t;

endpackage

/* rtl/core/record_preserving_byte_fifo_top.sv */
// Top level of the record-preserving byte FIFO: config register, controller
// and datapath. Depends on rpbf_pkg, rpbf_ctrl and rpbf_dp.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one item per handshake:
//   either one byte to write (with an end-of-record flag) or a read request
//   with a byte limit. Results leave on out_valid/out_stall/out_data.
//   A write byte with end-of-record gives one status item (bytes accepted);
//   other write bytes give none. A read gives one data item per byte, the
//   last one flagged, or a single "found nothing" item.
//   Flow: writes are taken back to back, one per cycle while the output is
//   free. A read fetches the head length from the length queue on accept, then
//   works out its byte count, then reads bytes from the byte store and sends
//   one per cycle while not stalled. An empty store or queue gives the "found
//   nothing" item on accept, zero bytes after the count. Results are registered.
//   Stall: while the output register holds an untaken item, the block holds
//   its current byte and accepts no new item; nothing is lost.
//   Reset (synchronous, rst_n low) clears pointers, queue indexes, the open
//   record and socket_kind (byte stream). The byte store and length queue
//   need no clearing pass, so the block is ready the cycle after reset.
//   STORE_BYTES and RECORD_SLOTS must be powers of two; the block does not check it.
//   Config: APB-style, socket_kind at byte address 0; write only when idle.
module record_preserving_byte_fifo_top
  import rpbf_pkg::*;
#(
  parameter int STORE_BYTES    = STORE_BYTES_DEF,
  parameter int RECORD_SLOTS   = RECORD_SLOTS_DEF,
  parameter int READ_MAX_BYTES = READ_MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  rpbf_in_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output rpbf_out_t         out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [1:0] socket_kind_r, socket_kind_nxt;
  logic       cfg_hit;
  rpbf_cmd_t  cmd;
  rpbf_stat_t stat;

  // Register decode: the word address bit picks the register.
  assign cfg_hit    = (cfg_paddr[2] == REG_SOCKET_KIND);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? CFG_DW'(socket_kind_r) : '0;

  always_comb begin
    socket_kind_nxt = socket_kind_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      socket_kind_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      socket_kind_r <= SK_STREAM;
    end else begin
      socket_kind_r <= socket_kind_nxt;
    end
  end

  rpbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpbf_dp #(
    .STORE_BYTES    (STORE_BYTES),
    .RECORD_SLOTS   (RECORD_SLOTS),
    .READ_MAX_BYTES (READ_MAX_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .socket_kind (socket_kind_r),
    .in_data     (in_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

/* rtl/core/rpbf_ctrl.sv */
// Controller for the record-preserving byte FIFO: sequences each item and
// drives datapath commands. Depends on rpbf_pkg.
module rpbf_ctrl
  import rpbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_stall,
  input  rpbf_stat_t stat,
  output rpbf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_BYTES
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign in_stall = !((state_r == ST_IDLE) && stat.out_free);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_mode == MODE_WRITE) begin
            cmd.wr_acc = 1'b1;
          end else if (stat.nothing) begin
            cmd.emit_none = 1'b1;
          end else begin
            cmd.len_rd = 1'b1;
            state_nxt  = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        cmd.ld_len = 1'b1;
        if (stat.n_zero) begin
          if (stat.out_free) begin
            cmd.emit_none = 1'b1;
            cmd.rp_adv    = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          cmd.byte_rd = 1'b1;
          state_nxt   = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          if (stat.last_byte) begin
            cmd.rp_adv = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.byte_rd = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A byte fetch is always followed by the byte phase.
  a_fetch_then_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_rd |=> (state_r == ST_BYTES))
    else $error("byte fetch not followed by byte phase");

endmodule

/* rtl/core/rpbf_dp.sv */
// Datapath for the record-preserving byte FIFO: byte store, length queue,
// pointers, open-record tracking and the output register. Depends on rpbf_pkg.
module rpbf_dp
  import rpbf_pkg::*;
#(
  parameter int STORE_BYTES    = STORE_BYTES_DEF,
  parameter int RECORD_SLOTS   = RECORD_SLOTS_DEF,
  parameter int READ_MAX_BYTES = READ_MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] socket_kind,
  input  rpbf_in_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output rpbf_out_t  out_data,
  input  rpbf_cmd_t  cmd,
  output rpbf_stat_t stat
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int PW  = AW + 1;
  localparam int QW  = $clog2(RECORD_SLOTS);
  localparam int QPW = QW + 1;
  localparam int NW  = $clog2(READ_MAX_BYTES + 1);

  logic [7:0]    store [STORE_BYTES];
  logic [PW-1:0] lenq  [RECORD_SLOTS];

  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0]  ocnt_r, ocnt_nxt;
  logic           odrop_r, odrop_nxt;
  logic [NW-1:0]  maxb_r, n_r, idx_r, idx_nxt;
  logic [PW-1:0]  consume_r;
  logic [7:0]     byte_q_r;
  logic [PW-1:0]  len_q_r;
  logic           out_valid_r, out_valid_nxt;
  rpbf_out_t      out_data_r, out_data_nxt;

  logic           rec;
  logic [PW-1:0]  used, used_a, cnt_a, wp_a, back, cnt_rep;
  logic [QPW-1:0] queued;
  logic           q_full, s_full, drop_a, take, eor;
  logic           wr_en, q_push, withdraw;
  logic [NW-1:0]  maxb_in;
  logic [PW-1:0]  maxb_p, n1, n_p, cons, rp_inc;
  logic [AW-1:0]  byte_addr;

  assign rec    = (socket_kind == SK_DGRAM) || (socket_kind == SK_SEQPKT);
  assign used   = wp_r - rp_r;
  assign queued = head_r - tail_r;
  assign q_full = (queued == QPW'(RECORD_SLOTS));
  assign s_full = (used == PW'(STORE_BYTES));
  assign eor    = in_data.end_of_record;

  // Write side: drop a whole record that meets a full queue, drop bytes
  // beyond free space, withdraw a record whose length cannot be queued.
  assign drop_a   = odrop_r || ((ocnt_r == '0) && rec && q_full);
  assign take     = !drop_a && !s_full;
  assign wr_en    = cmd.wr_acc && take;
  assign cnt_a    = ocnt_r + PW'(take);
  assign wp_a     = wp_r + PW'(take);
  assign used_a   = wp_a - rp_r;
  assign back     = (cnt_a < used_a) ? cnt_a : used_a;
  assign q_push   = cmd.wr_acc && eor && rec && (cnt_a != '0) && !q_full;
  assign withdraw = cmd.wr_acc && eor && rec && (cnt_a != '0) && q_full;
  assign cnt_rep  = withdraw ? '0 : cnt_a;

  // Read side.
  assign maxb_in = (in_data.read_max > RMAX_W'(READ_MAX_BYTES)) ?
                   NW'(READ_MAX_BYTES) : NW'(in_data.read_max);
  assign maxb_p  = PW'(maxb_r);
  assign n1      = (len_q_r < maxb_p) ? len_q_r : maxb_p;

  always_comb begin
    if (rec) begin
      n_p  = (n1 < used) ? n1 : used;
      cons = (len_q_r < used) ? len_q_r : used;
    end else begin
      n_p  = (used < maxb_p) ? used : maxb_p;
      cons = n_p;
    end
  end

  assign rp_inc = cmd.ld_len ? cons : consume_r;

  always_comb begin
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + NW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  assign byte_addr = rp_r[AW-1:0] + AW'(idx_nxt);

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.nothing   = (used == '0) || (rec && (queued == '0));
  assign stat.n_zero    = (n_p == '0);
  assign stat.last_byte = ((idx_r + NW'(1)) == n_r);

  // Pointer and open-record next state.
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ocnt_nxt  = ocnt_r;
    odrop_nxt = odrop_r;
    if (cmd.wr_acc) begin
      wp_nxt = withdraw ? (wp_a - back) : wp_a;
      if (eor) begin
        ocnt_nxt  = '0;
        odrop_nxt = 1'b0;
      end else begin
        ocnt_nxt  = cnt_a;
        odrop_nxt = drop_a || s_full;
      end
    end
    if (q_push) begin
      head_nxt = head_r + QPW'(1);
    end
    if (cmd.len_rd && rec) begin
      tail_nxt = tail_r + QPW'(1);
    end
    if (cmd.rp_adv) begin
      rp_nxt = rp_r + rp_inc;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.wr_acc && eor) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{kind: KIND_WSTAT, out_byte: 8'd0,
                        count: CNT_W'(cnt_rep), last: 1'b1};
    end else if (cmd.emit_none) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{kind: KIND_EMPTY, out_byte: 8'd0,
                        count: '0, last: 1'b1};
    end else if (cmd.emit_byte) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{kind: KIND_RDATA, out_byte: byte_q_r,
                        count: CNT_W'(n_r), last: stat.last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      ocnt_r      <= '0;
      odrop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ocnt_r      <= ocnt_nxt;
      odrop_r     <= odrop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    if (cmd.len_rd) begin
      maxb_r <= maxb_in;
    end
    if (cmd.ld_len) begin
      n_r       <= NW'(n_p);
      consume_r <= cons;
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wp_r[AW-1:0]] <= in_data.data_byte;
    end
    if (cmd.byte_rd) begin
      byte_q_r <= store[byte_addr];
    end
  end

  // Length queue memory.
  always_ff @(posedge clk) begin
    if (q_push) begin
      lenq[head_r[QW-1:0]] <= cnt_a;
    end
    if (cmd.len_rd) begin
      len_q_r <= lenq[tail_r[QW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= PW'(STORE_BYTES))
    else $error("byte store overfilled");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queued <= QPW'(RECORD_SLOTS))
    else $error("length queue overfilled");

  a_byte_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |-> (idx_r < n_r))
    else $error("byte emitted beyond read count");

endmodule
